// File: design/hnt_pkg.sv
// shared constants, codes and types of the held note tracker
package hnt_pkg;

  localparam int MAX_HELD_DEF = 32;
  localparam int NOTES        = 128;
  localparam int NOTE_W       = 7;
  localparam int VEL_W        = 7;
  localparam int STACK_W      = 8;
  localparam int HELD_W       = 6;
  localparam int IDX_W        = 6;
  localparam int TAG_W        = 32;

  localparam logic [IDX_W-1:0]   NO_SLOT   = '1;
  localparam logic [STACK_W-1:0] STACK_MAX = '1;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_REMOVE    = 3'd1;
  localparam logic [2:0] OP_LIST_ON   = 3'd2;
  localparam logic [2:0] OP_LIST_OFF  = 3'd3;
  localparam logic [2:0] OP_LIST_SON  = 3'd4;
  localparam logic [2:0] OP_LIST_SOFF = 3'd5;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_EVENT  = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_STACKED   = 3'd1;
  localparam logic [2:0] ST_UNSTACKED = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_HELD  = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  localparam logic [TAG_W-1:0] TYPE_NOTE_ON   = 32'h0000_0001;
  localparam logic [TAG_W-1:0] TYPE_NOTE_OFF  = 32'h4000_0000;
  localparam logic [TAG_W-1:0] TYPE_SOUND_ON  = 32'h0000_000d;
  localparam logic [TAG_W-1:0] TYPE_SOUND_OFF = 32'h4000_000c;

  localparam logic [VEL_W-1:0] VEL_LOW_CLAMP  = 7'd1;
  localparam logic [VEL_W-1:0] VEL_HIGH_CLAMP = 7'd127;

  localparam logic signed [7:0] NOTE_NONE = -8'sd1;

  typedef struct packed {
    logic [NOTE_W-1:0]  note;
    logic [VEL_W-1:0]   vel;
    logic [STACK_W-1:0] stack;
  } slot_t;

  typedef struct packed {
    logic              en;
    logic [NOTE_W-1:0] addr;
  } idx_rd_t;

  typedef struct packed {
    logic              en;
    logic [NOTE_W-1:0] addr;
    logic [IDX_W-1:0]  data;
  } idx_wr_t;

endpackage

// File: design/hnt_ifs.sv
// handshake channels of the held note tracker

interface hnt_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [6:0]         note_number;
  logic [6:0]         velocity;
  logic [7:0]         stack_count;
  logic signed [7:0]  velocity_delta;

  modport source (output valid, op, note_number, velocity, stack_count, velocity_delta,
                  input ready);
  modport sink   (input valid, op, note_number, velocity, stack_count, velocity_delta,
                  output ready);
endinterface

interface hnt_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [2:0]         status;
  logic [31:0]        event_tag;
  logic [5:0]         held_total;
  logic signed [7:0]  lowest_note;
  logic signed [7:0]  highest_note;
  logic               last;

  modport source (output valid, kind, status, event_tag, held_total, lowest_note,
                  highest_note, last, input ready);
  modport sink   (input valid, kind, status, event_tag, held_total, lowest_note,
                  highest_note, last, output ready);
endinterface

interface hnt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] channel;

  modport source (output valid, channel, input ready);
  modport sink   (input valid, channel, output ready);
endinterface

// File: design/hnt_index.sv
// note to slot index store with per-note valid bits
module hnt_index (
  input  logic                   clk,
  input  logic                   rst,
  input  hnt_pkg::idx_rd_t       rd,
  input  hnt_pkg::idx_wr_t       wr,
  output logic [hnt_pkg::IDX_W-1:0] rd_slot
);
  import hnt_pkg::*;

  logic [IDX_W-1:0] mem [NOTES];
  logic [NOTES-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // never written entries read as no slot
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_slot <= vld[rd.addr] ? mem[rd.addr] : NO_SLOT;
    end
  end

endmodule

// File: design/held_note_tracker.sv
// held note tracker: slot list of held notes of one channel with list event output
// One item is taken at a time; cmd.ready is high only while the sequencer is idle.
// Insert and remove that leave the set of held notes unchanged reach the result register
// without a rescan; when the set changes, a rescan of the slot memory for the lowest and
// highest note follows, one slot per cycle, before the result is loaded. List operations
// read the slot memory once per held slot and deliver one event item per cycle while
// res.ready stays high; an empty list gives a single item. The slot memory has a single
// read port. The index store needs no clearing pass after reset.
module held_note_tracker #(
  parameter int MAX_HELD = hnt_pkg::MAX_HELD_DEF
) (
  input  logic      clk,
  input  logic      rst,
  hnt_cmd_if.sink   cmd,
  hnt_res_if.source res,
  hnt_cfg_if.sink   cfg
);
  import hnt_pkg::*;

  localparam int SW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam logic [HELD_W-1:0] HELD_LIMIT = HELD_W'(MAX_HELD);

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_SLOT, S_MOVE, S_SCAN, S_EMIT, S_LIST
  } state_t;

  state_t             state;
  logic [7:0]         channel;
  logic [2:0]         op_q;
  logic [NOTE_W-1:0]  note_q;
  logic [VEL_W-1:0]   vel_q;
  logic [STACK_W-1:0] stk_q;
  logic [7:0]         delta_q;
  logic [1:0]         kind_q;
  logic [2:0]         status_q;
  logic [IDX_W-1:0]   slot_s;
  logic [HELD_W-1:0]  held;
  logic [7:0]         lo;
  logic [7:0]         hi;
  logic               scan_any;
  logic               scan_pend;
  logic [HELD_W-1:0]  scan_i;
  logic [HELD_W-1:0]  list_i;

  slot_t              slot_mem [MAX_HELD];
  slot_t              cur;
  logic               sl_we;
  logic               sl_re;
  logic [SW-1:0]      sl_wa;
  logic [SW-1:0]      sl_ra;
  slot_t              sl_wd;

  idx_rd_t            ix_rd;
  idx_wr_t            ix_wr;
  logic [IDX_W-1:0]   idx_q;

  logic               accept;
  logic               is_upd;
  logic               is_list;
  logic               out_free;
  logic               res_load;
  logic               s_hit;
  logic [HELD_W-1:0]  held_m1;
  logic               list_last;
  logic               scan_more;
  logic signed [8:0]  vsum;
  logic [VEL_W-1:0]   v_on;
  logic [VEL_W-1:0]   tag_vel;
  logic [TAG_W-1:0]   type_code;
  logic [TAG_W-1:0]   tag;
  logic [7:0]         cur_note8;

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign is_upd    = (cmd.op == OP_INSERT) || (cmd.op == OP_REMOVE);
  assign is_list   = (cmd.op == OP_LIST_ON) || (cmd.op == OP_LIST_OFF) ||
                     (cmd.op == OP_LIST_SON) || (cmd.op == OP_LIST_SOFF);
  assign out_free  = !res.valid || res.ready;
  assign res_load  = out_free && ((state == S_EMIT) || (state == S_LIST));
  assign s_hit     = idx_q < held;
  assign held_m1   = held - HELD_W'(1);
  assign list_last = (list_i + HELD_W'(1)) == held;
  assign scan_more = scan_i < held;
  assign cur_note8 = {1'b0, cur.note};

  always_ff @(posedge clk) begin
    if (rst) begin
      channel <= '0;
    end else if (cfg.valid && cfg.ready) begin
      channel <= cfg.channel;
    end
  end

  hnt_index u_index (
    .clk     (clk),
    .rst     (rst),
    .rd      (ix_rd),
    .wr      (ix_wr),
    .rd_slot (idx_q)
  );

  // slot memory
  always_ff @(posedge clk) begin
    if (sl_we) begin
      slot_mem[sl_wa] <= sl_wd;
    end
    if (sl_re) begin
      cur <= slot_mem[sl_ra];
    end
  end

  // event tag
  always_comb begin
    vsum = $signed({2'b00, cur.vel}) + $signed({delta_q[7], delta_q});
    if (vsum[8] || vsum[7]) begin
      v_on = delta_q[7] ? VEL_LOW_CLAMP : VEL_HIGH_CLAMP;
    end else begin
      v_on = vsum[6:0];
    end
    case (op_q)
      OP_LIST_ON: begin
        type_code = TYPE_NOTE_ON;
        tag_vel   = v_on;
      end
      OP_LIST_OFF: begin
        type_code = TYPE_NOTE_OFF;
        tag_vel   = '0;
      end
      OP_LIST_SON: begin
        type_code = TYPE_SOUND_ON;
        tag_vel   = cur.vel;
      end
      default: begin
        type_code = TYPE_SOUND_OFF;
        tag_vel   = '0;
      end
    endcase
    tag = type_code | {1'b0, tag_vel, 1'b0, cur.note, channel, 8'h00};
  end

  // memory port control
  always_comb begin
    sl_we      = 1'b0;
    sl_wa      = '0;
    sl_wd      = cur;
    sl_re      = 1'b0;
    sl_ra      = '0;
    ix_rd.en   = 1'b0;
    ix_rd.addr = cmd.note_number;
    ix_wr.en   = 1'b0;
    ix_wr.addr = note_q;
    ix_wr.data = NO_SLOT;
    unique case (state)
      S_IDLE: begin
        ix_rd.en = accept && is_upd;
        sl_re    = accept && is_list && (held != '0);
      end
      S_LOOK: begin
        if (s_hit) begin
          sl_re = 1'b1;
          sl_ra = idx_q[SW-1:0];
        end else if (op_q == OP_INSERT && held < HELD_LIMIT) begin
          sl_we      = 1'b1;
          sl_wa      = held[SW-1:0];
          sl_wd      = '{note: note_q, vel: vel_q, stack: stk_q};
          ix_wr.en   = 1'b1;
          ix_wr.data = held;
        end
      end
      S_SLOT: begin
        sl_wa = slot_s[SW-1:0];
        if (op_q == OP_INSERT) begin
          sl_we = 1'b1;
          if (cur.stack != STACK_MAX) begin
            sl_wd.stack = cur.stack + STACK_W'(1);
          end
        end else if (cur.stack != '0) begin
          sl_we       = 1'b1;
          sl_wd.stack = cur.stack - STACK_W'(1);
        end else begin
          ix_wr.en = 1'b1;
          if (slot_s < held_m1) begin
            sl_re = 1'b1;
            sl_ra = held_m1[SW-1:0];
          end
        end
      end
      S_MOVE: begin
        sl_we      = 1'b1;
        sl_wa      = slot_s[SW-1:0];
        ix_wr.en   = 1'b1;
        ix_wr.addr = cur.note;
        ix_wr.data = slot_s;
      end
      S_SCAN: begin
        sl_re = scan_more;
        sl_ra = scan_i[SW-1:0];
      end
      S_LIST: begin
        sl_re = out_free && !list_last;
        sl_ra = SW'(list_i + HELD_W'(1));
      end
      default: begin
        sl_re = 1'b0;
      end
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      lo        <= NOTE_NONE;
      hi        <= NOTE_NONE;
      scan_any  <= 1'b0;
      scan_pend <= 1'b0;
      scan_i    <= '0;
      list_i    <= '0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && !res_load) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q     <= cmd.op;
            note_q   <= cmd.note_number;
            vel_q    <= cmd.velocity;
            stk_q    <= cmd.stack_count;
            delta_q  <= cmd.velocity_delta;
            kind_q   <= (is_list && held == '0) ? KIND_EMPTY : KIND_STATUS;
            status_q <= ST_ADDED;
            list_i   <= '0;
            if (is_upd) begin
              state <= S_LOOK;
            end else if (is_list) begin
              if (held == '0) begin
                state <= S_EMIT;
              end else begin
                state <= S_LIST;
              end
            end
          end
        end
        S_LOOK: begin
          slot_s <= idx_q;
          if (s_hit) begin
            state <= S_SLOT;
          end else if (op_q == OP_INSERT) begin
            if (held < HELD_LIMIT) begin
              held      <= held + HELD_W'(1);
              status_q  <= ST_ADDED;
              lo        <= NOTE_NONE;
              hi        <= NOTE_NONE;
              scan_any  <= 1'b0;
              scan_pend <= 1'b0;
              scan_i    <= '0;
              state     <= S_SCAN;
            end else begin
              status_q <= ST_FULL;
              state    <= S_EMIT;
            end
          end else begin
            status_q <= ST_NOT_HELD;
            state    <= S_EMIT;
          end
        end
        S_SLOT: begin
          if (op_q == OP_INSERT) begin
            status_q <= ST_STACKED;
            state    <= S_EMIT;
          end else if (cur.stack != '0) begin
            status_q <= ST_UNSTACKED;
            state    <= S_EMIT;
          end else begin
            status_q  <= ST_REMOVED;
            held      <= held_m1;
            lo        <= NOTE_NONE;
            hi        <= NOTE_NONE;
            scan_any  <= 1'b0;
            scan_pend <= 1'b0;
            scan_i    <= '0;
            state     <= (slot_s < held_m1) ? S_MOVE : S_SCAN;
          end
        end
        S_MOVE: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_pend) begin
            scan_any <= 1'b1;
            if (!scan_any || cur_note8 < lo) begin
              lo <= cur_note8;
            end
            if (!scan_any || cur_note8 > hi) begin
              hi <= cur_note8;
            end
          end
          scan_pend <= scan_more;
          if (scan_more) begin
            scan_i <= scan_i + HELD_W'(1);
          end else if (!scan_pend) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            res.valid        <= 1'b1;
            res.kind         <= kind_q;
            res.status       <= (kind_q == KIND_STATUS) ? status_q : ST_ADDED;
            res.event_tag    <= '0;
            res.held_total   <= held;
            res.lowest_note  <= lo;
            res.highest_note <= hi;
            res.last         <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_LIST: begin
          if (out_free) begin
            res.valid        <= 1'b1;
            res.kind         <= KIND_EVENT;
            res.status       <= ST_ADDED;
            res.event_tag    <= tag;
            res.held_total   <= held;
            res.lowest_note  <= lo;
            res.highest_note <= hi;
            res.last         <= list_last;
            list_i           <= list_i + HELD_W'(1);
            if (list_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.kind == KIND_STATUS || res.kind == KIND_EMPTY) |-> res.last)
    else $error("status or empty item without last");

  a_held_step: assert property (@(posedge clk) disable iff (rst)
    held != $past(held) |->
      (held == $past(held) + HELD_W'(1)) || (held + HELD_W'(1) == $past(held)))
    else $error("held count moved by more than one");

  a_empty_extremes: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.held_total == '0 |->
      res.lowest_note == NOTE_NONE && res.highest_note == NOTE_NONE)
    else $error("extremes not cleared with no held notes");

  a_held_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready && cmd.op == OP_INSERT && held == HELD_LIMIT |=>
      held == HELD_LIMIT)
    else $error("insert exceeded the slot limit");

endmodule

// File: dv/testbench.sv
// self-checking testbench of the held note tracker with directed and random note commands
module testbench;
  import hnt_pkg::*;

  localparam int HELD_CAP        = MAX_HELD_DEF;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE          = 60;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int REPORT_MAX      = 10;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_CHURN} mix_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [6:0]        note;
    logic [6:0]        vel;
    logic [7:0]        stack;
    logic signed [7:0] delta;
  } note_cmd_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [2:0]        status;
    logic [31:0]       tag;
    logic [5:0]        held;
    logic signed [7:0] lowest;
    logic signed [7:0] highest;
    logic              last;
  } note_result_t;

  logic clk = 1'b0;
  logic rst;

  hnt_cmd_if cmd ();
  hnt_res_if res ();
  hnt_cfg_if cfg ();

  held_note_tracker dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .res(res),
    .cfg(cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted state of the held note set
  logic [6:0] slot_note_q  [HELD_CAP];
  logic [6:0] slot_vel_q   [HELD_CAP];
  logic [7:0] slot_stack_q [HELD_CAP];
  logic [5:0] slot_of_note [NOTES];
  int         held_now = 0;
  logic [7:0] chan_now = '0;

  note_result_t due_results [$];
  note_cmd_t    cmd_backlog [$];
  logic [6:0]   gen_held [$];

  note_cmd_t    cmd_cur;
  note_result_t res_got;
  note_result_t res_want;

  int cmds_taken   = 0;
  int results_seen = 0;
  int fail_count   = 0;
  int full_drops   = 0;
  int chan_writes  = 0;
  int cycle_count  = 0;
  int cmd_wait     = 0;
  int cmd_calm     = 0;
  int res_wait     = 0;
  int res_calm     = 0;

  function automatic int draw_pause(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 12);
  endfunction

  function automatic string show_result(note_result_t r);
    return $sformatf("kind %0d status %0d tag %h held %0d low %0d high %0d last %0d",
                     r.kind, r.status, r.tag, r.held, r.lowest, r.highest, r.last);
  endfunction

  function automatic void push_result(logic [1:0] kind, logic [2:0] status,
                                      logic [31:0] tag, logic last);
    note_result_t r;
    int lo;
    int hi;
    int i;
    lo = -1;
    hi = -1;
    for (i = 0; i < held_now; i++) begin
      if (i == 0 || int'(slot_note_q[i]) < lo) lo = int'(slot_note_q[i]);
      if (i == 0 || int'(slot_note_q[i]) > hi) hi = int'(slot_note_q[i]);
    end
    r.kind    = kind;
    r.status  = status;
    r.tag     = tag;
    r.held    = 6'(held_now);
    r.lowest  = 8'(lo);
    r.highest = 8'(hi);
    r.last    = last;
    due_results.push_back(r);
  endfunction

  function automatic logic [5:0] slot_for(logic [6:0] note);
    logic [5:0] s;
    s = slot_of_note[note];
    if (int'(s) >= held_now) s = NO_SLOT;
    return s;
  endfunction

  function automatic void apply_note_cmd(note_cmd_t c);
    logic [5:0]  s;
    logic [5:0]  tail;
    logic [2:0]  st;
    logic [31:0] base;
    logic [31:0] tag;
    int          v;
    int          i;
    case (c.op)
      OP_INSERT: begin
        s = slot_for(c.note);
        if (s != NO_SLOT) begin
          if (slot_stack_q[s] != STACK_MAX) slot_stack_q[s]++;
          st = ST_STACKED;
        end else if (held_now >= HELD_CAP) begin
          st = ST_FULL;
          full_drops++;
        end else begin
          slot_note_q[held_now]  = c.note;
          slot_vel_q[held_now]   = c.vel;
          slot_stack_q[held_now] = c.stack;
          slot_of_note[c.note]   = 6'(held_now);
          held_now++;
          st = ST_ADDED;
        end
        push_result(KIND_STATUS, st, '0, 1'b1);
      end
      OP_REMOVE: begin
        s = slot_for(c.note);
        if (s == NO_SLOT) begin
          st = ST_NOT_HELD;
        end else if (slot_stack_q[s] != '0) begin
          slot_stack_q[s]--;
          st = ST_UNSTACKED;
        end else begin
          held_now--;
          tail = 6'(held_now);
          slot_of_note[c.note] = NO_SLOT;
          // last slot fills the hole
          if (s < tail) begin
            slot_note_q[s]  = slot_note_q[tail];
            slot_vel_q[s]   = slot_vel_q[tail];
            slot_stack_q[s] = slot_stack_q[tail];
            slot_of_note[slot_note_q[s]] = s;
          end
          st = ST_REMOVED;
        end
        push_result(KIND_STATUS, st, '0, 1'b1);
      end
      OP_LIST_ON, OP_LIST_OFF, OP_LIST_SON, OP_LIST_SOFF: begin
        if (held_now == 0) begin
          push_result(KIND_EMPTY, '0, '0, 1'b1);
        end else begin
          case (c.op)
            OP_LIST_ON:  base = TYPE_NOTE_ON;
            OP_LIST_OFF: base = TYPE_NOTE_OFF;
            OP_LIST_SON: base = TYPE_SOUND_ON;
            default:     base = TYPE_SOUND_OFF;
          endcase
          base = base | {16'b0, chan_now, 8'b0};
          for (i = 0; i < held_now; i++) begin
            tag = base | {9'b0, slot_note_q[i], 16'b0};
            if (c.op == OP_LIST_ON) begin
              v = int'(slot_vel_q[i]) + int'($signed(c.delta));
              if (v < 0 || v > int'(VEL_HIGH_CLAMP)) begin
                v = ($signed(c.delta) < 0) ? int'(VEL_LOW_CLAMP) : int'(VEL_HIGH_CLAMP);
              end
              tag = tag | {1'b0, 7'(v), 24'b0};
            end else if (c.op == OP_LIST_SON) begin
              tag = tag | {1'b0, slot_vel_q[i], 24'b0};
            end
            push_result(KIND_EVENT, '0, tag, i == held_now - 1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_cmd(logic [2:0] op, logic [6:0] note, logic [6:0] vel,
                                    logic [7:0] stack, logic signed [7:0] delta);
    note_cmd_t c;
    c.op    = op;
    c.note  = note;
    c.vel   = vel;
    c.stack = stack;
    c.delta = delta;
    cmd_backlog.push_back(c);
  endfunction

  task automatic queue_random_cmds(input int count);
    int         made;
    int         seg_left;
    int         pick;
    int         ins_cut;
    int         rem_cut;
    int         at;
    mix_t       mix;
    logic [2:0] op;
    logic [6:0] note;
    logic [7:0] stack;
    made     = 0;
    seg_left = 0;
    mix      = MIX_FILL;
    while (made < count) begin
      if (seg_left == 0) begin
        mix      = mix_t'($urandom_range(0, 2));
        seg_left = $urandom_range(20, 45);
      end
      seg_left--;
      pick  = $urandom_range(0, 99);
      note  = 7'($urandom);
      stack = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 2)) : 8'd0;
      // small note pool so that stacking and saturation get hit
      if (mix == MIX_CHURN) begin
        note = 7'(60 + $urandom_range(0, 5));
        case ($urandom_range(0, 7))
          0: stack = STACK_MAX;
          1: stack = 8'($urandom);
          default: ;
        endcase
      end
      case (mix)
        MIX_FILL:  begin ins_cut = 70; rem_cut = 82; end
        MIX_DRAIN: begin ins_cut = 20; rem_cut = 75; end
        default:   begin ins_cut = 45; rem_cut = 85; end
      endcase
      if (pick < 3) begin
        op = pick[0] ? OP_SPARE_HI : OP_SPARE_LO;
      end else begin
        made++;
        if (pick < ins_cut) begin
          op = OP_INSERT;
        end else if (pick < rem_cut) begin
          op = OP_REMOVE;
          if (mix != MIX_CHURN && gen_held.size() != 0 && $urandom_range(0, 9) != 0) begin
            note = gen_held[$urandom_range(0, gen_held.size() - 1)];
          end
        end else begin
          case ($urandom_range(0, 3))
            0:       op = OP_LIST_ON;
            1:       op = OP_LIST_OFF;
            2:       op = OP_LIST_SON;
            default: op = OP_LIST_SOFF;
          endcase
        end
        at = -1;
        foreach (gen_held[k]) if (gen_held[k] == note) at = k;
        if (op == OP_INSERT && at < 0 && gen_held.size() < HELD_CAP) gen_held.push_back(note);
        if (op == OP_REMOVE && at >= 0) gen_held.delete(at);
      end
      queue_cmd(op, note, 7'($urandom), stack, 8'($urandom));
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || cmd.valid || due_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_channel(input logic [7:0] value);
    @(posedge clk);
    cfg.channel <= value;
    cfg.valid   <= 1'b1;
    do @(posedge clk);
    while (!cfg.ready);
    chan_now = value;
    chan_writes++;
    cfg.valid <= 1'b0;
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
      cmd_wait = 0;
    end else if (!cmd.valid || cmd.ready) begin
      if (cmd.valid) begin
        apply_note_cmd(cmd_cur);
        cmds_taken++;
      end
      if (cmd_wait > 0) begin
        cmd_wait--;
        cmd.valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        cmd_cur = cmd_backlog.pop_front();
        cmd.op             <= cmd_cur.op;
        cmd.note_number    <= cmd_cur.note;
        cmd.velocity       <= cmd_cur.vel;
        cmd.stack_count    <= cmd_cur.stack;
        cmd.velocity_delta <= cmd_cur.delta;
        cmd.valid          <= 1'b1;
        cmd_wait = draw_pause(cmd_calm);
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      res_wait = 0;
    end else begin
      if (res.valid && res.ready) begin
        res_got = {res.kind, res.status, res.event_tag, res.held_total,
                   res.lowest_note, res.highest_note, res.last};
        results_seen++;
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("unexpected result %0d: %s", results_seen, show_result(res_got));
          end
        end else begin
          res_want = due_results.pop_front();
          if (res_got !== res_want) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("result %0d mismatch", results_seen);
              $display("  expected %s", show_result(res_want));
              $display("  actual   %s", show_result(res_got));
            end
          end
        end
        res_wait = draw_pause(res_calm);
      end
      if (res_wait > 0) begin
        res_wait--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, due_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int phase;
    rst                = 1'b1;
    cmd.valid          = 1'b0;
    cmd.op             = OP_INSERT;
    cmd.note_number    = '0;
    cmd.velocity       = '0;
    cmd.stack_count    = '0;
    cmd.velocity_delta = '0;
    res.ready          = 1'b0;
    cfg.valid          = 1'b0;
    cfg.channel        = '0;
    foreach (slot_of_note[n]) slot_of_note[n] = NO_SLOT;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part on the reset channel
    queue_cmd(OP_LIST_ON,   7'd0,   7'd0,   8'd0,   8'sd0);
    queue_cmd(OP_LIST_SOFF, 7'd0,   7'd0,   8'd0,   8'sd0);
    queue_cmd(OP_REMOVE,    7'd5,   7'd0,   8'd0,   8'sd0);
    queue_cmd(OP_INSERT,    7'd0,   7'd0,   8'd0,   8'sd0);
    queue_cmd(OP_INSERT,    7'd127, 7'd127, 8'd255, 8'sd0);
    queue_cmd(OP_INSERT,    7'd127, 7'd0,   8'd0,   8'sd0);
    queue_cmd(OP_INSERT,    7'd0,   7'd5,   8'd9,   8'sd0);
    queue_cmd(OP_INSERT,    7'd64,  7'd100, 8'd0,   8'sd0);
    queue_cmd(OP_LIST_ON,   7'd0,   7'd0,   8'd0,   -8'sd128);
    queue_cmd(OP_LIST_ON,   7'd0,   7'd0,   8'd0,   8'sd127);
    queue_cmd(OP_LIST_ON,   7'd0,   7'd0,   8'd0,   8'sd0);
    queue_cmd(OP_LIST_OFF,  7'd0,   7'd0,   8'd0,   8'sd0);
    queue_cmd(OP_LIST_SON,  7'd0,   7'd0,   8'd0,   8'sd0);
    queue_cmd(OP_LIST_SOFF, 7'd0,   7'd0,   8'd0,   8'sd0);
    queue_cmd(OP_SPARE_LO,  7'd127, 7'd127, 8'd255, -8'sd1);
    queue_cmd(OP_SPARE_HI,  7'd64,  7'd1,   8'd1,   8'sd1);
    queue_cmd(OP_REMOVE,    7'd0,   7'd0,   8'd0,   8'sd0);
    queue_cmd(OP_REMOVE,    7'd0,   7'd0,   8'd0,   8'sd0);
    queue_cmd(OP_REMOVE,    7'd0,   7'd0,   8'd0,   8'sd0);
    queue_cmd(OP_LIST_SON,  7'd0,   7'd0,   8'd0,   8'sd0);
    queue_cmd(OP_REMOVE,    7'd64,  7'd0,   8'd0,   8'sd0);
    queue_cmd(OP_LIST_ON,   7'd0,   7'd0,   8'd0,   -8'sd5);
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_channel(8'hff);
        2:       write_channel(8'h00);
        default: write_channel(8'($urandom));
      endcase
      queue_random_cmds(ITEMS_PER_PHASE);
      wait_drained();
    end

    $display("%0d commands taken, %0d results checked over %0d channel writes",
             cmds_taken, results_seen, chan_writes);
    $display("%0d inserts dropped on a full list, %0d failures", full_drops, fail_count);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
